[hdl/mmbd_pkg.sv]
// Shared constants, codes and types of the mipmap box downsampler.
package mmbd_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int LANES_DEF     = 4;
	localparam int COMP_W        = 16;
	localparam int SUM_W         = 17;
	localparam int PAIR_W        = 18;

	// Component modes: bit 1 selects 16-bit components, bit 0 selects signed.
	localparam logic [1:0] MODE_U8  = 2'd0;
	localparam logic [1:0] MODE_S8  = 2'd1;
	localparam logic [1:0] MODE_U16 = 2'd2;
	localparam logic [1:0] MODE_S16 = 2'd3;

	localparam logic [1:0] ALPHA_AVG    = 2'd0;
	localparam logic [1:0] ALPHA_FORCE  = 2'd1;
	localparam logic [1:0] ALPHA_THRESH = 2'd2;

	localparam logic [7:0] ALPHA_FULL = 8'hFF;
	localparam logic [7:0] ALPHA_HALF = 8'h80;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_ALPHA = 2'd2;
	localparam logic [1:0] REG_WIDTH = 2'd3;

	// Per-lane control for the averaging unit.
	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] alpha_mode;
		logic       active;
		logic       is_alpha;
	} lane_ctrl_t;

endpackage

[hdl/mmbd_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module mmbd_ram #(
	parameter int WIDTH = 68,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/mmbd_avg.sv]
// One lane of the final 2x2 average: total, rounding, output masking and alpha.
module mmbd_avg (
	input  logic signed [mmbd_pkg::PAIR_W-1:0] pair,
	input  logic [mmbd_pkg::SUM_W-1:0]         stored,
	input  mmbd_pkg::lane_ctrl_t               ctrl,
	output logic [mmbd_pkg::COMP_W-1:0]        result
);

	logic [18:0] total;
	logic [18:0] adj;
	logic        neg;
	logic [15:0] avg;

	always_comb begin
		// The stored pair sum is reinterpreted as signed in the signed modes.
		total = {pair[17], pair} +
			{{2{ctrl.mode[0] & stored[16]}}, stored};
		// Signed division by four truncates toward zero: bias negatives by three.
		neg   = ctrl.mode[0] & total[18];
		adj   = total + {17'd0, neg, neg};
		avg   = adj[17:2];
		if (!ctrl.active) begin
			result = '0;
		end else if (ctrl.mode[1]) begin
			result = avg;
		end else begin
			result = {8'd0, avg[7:0]};
			if (ctrl.is_alpha && ctrl.mode == mmbd_pkg::MODE_U8) begin
				if (ctrl.alpha_mode == mmbd_pkg::ALPHA_FORCE) begin
					result = {8'd0, mmbd_pkg::ALPHA_FULL};
				end else if (ctrl.alpha_mode == mmbd_pkg::ALPHA_THRESH) begin
					result = (avg[7:0] >= mmbd_pkg::ALPHA_HALF) ?
						{8'd0, mmbd_pkg::ALPHA_FULL} : '0;
				end
			end
		end
	end

endmodule

[hdl/mipmap_box_downsampler_top.sv]
// Top level of the 2x2 box-filter mipmap downsampler.
//
// The block takes one source pixel per item in raster order and emits one
// pixel of the next mipmap level on the bottom-right pixel of every 2x2 block.
// It accepts one item per clock cycle whatever the row width, unless the
// output stalls while stage 1 and the output register are full; the figure
// is set by the line store, a single RAM that sees at most one write (even
// rows) or one read (odd rows) per item. A result goes through the line
// store read and stage 1, then the output register, which lets the
// input keep flowing while a finished result waits to be taken. On an even
// row the horizontal pair sum of each component is written to the line store;
// on an odd row it is added to the stored sum and divided by four, flooring in
// the unsigned modes and truncating toward zero in the signed modes. The line
// store holds LANES 17-bit sums per pair of the widest row; it is not
// cleared after reset, so the first row after reset or frame end must be an
// even row, which the block guarantees by returning to row 0 on frame_end.
// Because a write and the read of the same entry are a full row apart, no
// forwarding is needed. Configuration may change only while the block is idle.
module mipmap_box_downsampler_top #(
	parameter int MAX_WIDTH = mmbd_pkg::MAX_WIDTH_DEF,
	parameter int LANES     = mmbd_pkg::LANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] comp0_in,
	input  logic [15:0] comp1_in,
	input  logic [15:0] comp2_in,
	input  logic [15:0] comp3_in,
	input  logic        frame_end,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] comp0_out,
	output logic [15:0] comp1_out,
	output logic [15:0] comp2_out,
	output logic [15:0] comp3_out,
	output logic        level_end,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Largest usable row width is the largest power of two within MAX_WIDTH.
	localparam int MAXL       = $clog2(MAX_WIDTH + 1) - 1;
	localparam int CPW        = (MAXL < 2) ? 2 : MAXL;
	localparam int AW         = CPW - 1;
	localparam int DEPTH      = 2 ** AW;
	localparam int LANE_LIMIT = (LANES < 4) ? LANES : 4;
	localparam int SW         = mmbd_pkg::SUM_W;
	localparam int PW         = mmbd_pkg::PAIR_W;
	localparam int CW         = mmbd_pkg::COMP_W;

	// Configuration registers.
	logic [1:0] component_mode_q;
	logic [2:0] component_count_q;
	logic [1:0] alpha_mode_q;
	logic [3:0] row_width_log2_q;

	// Position and left-pixel state.
	logic [CPW-1:0] colpos_q;
	logic           odd_row_q;
	logic [CW-1:0]  hold_q [LANES];

	// Pipeline registers.
	logic                 valid_s1;
	logic signed [PW-1:0] pair_s1 [LANES];
	logic                 fend_s1;
	logic                 valid_s2;
	logic [CW-1:0]        comp_s2 [4];
	logic                 fend_s2;

	logic [CW-1:0]        comp_in [4];
	logic [CW-1:0]        lane_res [4];
	logic signed [PW-1:0] pair [LANES];
	logic [4:0]           eff_log2;
	logic [2:0]           eff_count;
	logic [CPW-1:0]       col_mask;
	logic [CPW-1:0]       col;
	logic                 col_last;
	logic                 produce;
	logic                 in_accept;
	logic                 cfg_write;
	logic                 out_free;
	logic                 s1_adv;
	logic                 ram_we;
	logic                 ram_re;
	logic [AW-1:0]        ram_addr;
	logic [LANES*SW-1:0]  ram_wdata;
	logic [LANES*SW-1:0]  ram_rdata;

	function automatic logic signed [16:0] decode(input logic [15:0] raw,
			input logic [1:0] mode);
		logic signed [16:0] val;
		unique case (mode)
			mmbd_pkg::MODE_U8:  val = {9'd0, raw[7:0]};
			mmbd_pkg::MODE_S8:  val = {{9{raw[7]}}, raw[7:0]};
			mmbd_pkg::MODE_U16: val = {1'b0, raw};
			mmbd_pkg::MODE_S16: val = {raw[15], raw};
			default:            val = '0;
		endcase
		return val;
	endfunction

	assign comp_in[0] = comp0_in;
	assign comp_in[1] = comp1_in;
	assign comp_in[2] = comp2_in;
	assign comp_in[3] = comp3_in;

	// Configuration port: no wait states, every register readable.
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			component_mode_q  <= mmbd_pkg::MODE_U8;
			component_count_q <= 3'd4;
			alpha_mode_q      <= mmbd_pkg::ALPHA_AVG;
			row_width_log2_q  <= 4'd1;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				mmbd_pkg::REG_MODE:  component_mode_q  <= pwdata[1:0];
				mmbd_pkg::REG_COUNT: component_count_q <= pwdata[2:0];
				mmbd_pkg::REG_ALPHA: alpha_mode_q      <= pwdata[1:0];
				mmbd_pkg::REG_WIDTH: row_width_log2_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			mmbd_pkg::REG_MODE:  prdata = {30'd0, component_mode_q};
			mmbd_pkg::REG_COUNT: prdata = {29'd0, component_count_q};
			mmbd_pkg::REG_ALPHA: prdata = {30'd0, alpha_mode_q};
			mmbd_pkg::REG_WIDTH: prdata = {28'd0, row_width_log2_q};
			default:             prdata = '0;
		endcase
	end

	// Effective row width and component count, with out-of-range values clamped.
	always_comb begin
		if (row_width_log2_q == 4'd0) begin
			eff_log2 = 5'd1;
		end else if ({1'b0, row_width_log2_q} > 5'(MAXL)) begin
			eff_log2 = 5'(MAXL);
		end else begin
			eff_log2 = {1'b0, row_width_log2_q};
		end
		if (component_count_q == 3'd0) begin
			eff_count = 3'd1;
		end else if (component_count_q > 3'(LANE_LIMIT)) begin
			eff_count = 3'(LANE_LIMIT);
		end else begin
			eff_count = component_count_q;
		end
	end

	assign col_mask = ~({CPW{1'b1}} << eff_log2);
	assign col      = colpos_q & col_mask;
	assign col_last = (col == col_mask);
	assign produce  = col[0] & odd_row_q;
	assign ram_addr = col[CPW-1:1];

	// Handshake: the first stage moves when it is empty or the output frees up.
	assign out_free  = ~valid_s2 | ~out_stall;
	assign s1_adv    = ~valid_s1 | out_free;
	assign in_stall  = ~s1_adv;
	assign in_accept = in_valid & ~in_stall;

	// Horizontal pair sums of the left (held) pixel and the current pixel.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pair[i] = PW'(decode(hold_q[i], component_mode_q)) +
				PW'(decode(comp_in[i], component_mode_q));
			ram_wdata[i*SW +: SW] = pair[i][SW-1:0];
		end
	end

	// Even rows write the pair sums; odd rows read them back for the average.
	assign ram_we = in_accept & col[0] & ~odd_row_q;
	assign ram_re = in_accept & produce;

	mmbd_ram #(
		.WIDTH(LANES * SW),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_addr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_addr),
		.rdata(ram_rdata)
	);

	// Column and row tracking plus the held left pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colpos_q  <= '0;
			odd_row_q <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				hold_q[i] <= '0;
			end
		end else if (in_accept) begin
			if (!col[0]) begin
				for (int i = 0; i < LANES; i++) begin
					hold_q[i] <= comp_in[i];
				end
			end
			if (frame_end) begin
				colpos_q  <= '0;
				odd_row_q <= 1'b0;
			end else if (col_last) begin
				colpos_q  <= '0;
				odd_row_q <= ~odd_row_q;
			end else begin
				colpos_q  <= col + CPW'(1);
			end
		end
	end

	// Stage 1 holds the pair sums while the line store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= in_accept & produce;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && in_accept && produce) begin
			pair_s1 <= pair;
			fend_s1 <= frame_end;
		end
	end

	// Final averaging, one unit per lane; lanes beyond LANES read as zero.
	for (genvar g = 0; g < 4; g++) begin : g_lane
		if (g < LANES) begin : g_used
			mmbd_pkg::lane_ctrl_t ctrl;

			assign ctrl.mode       = component_mode_q;
			assign ctrl.alpha_mode = alpha_mode_q;
			assign ctrl.active     = (3'(g) < eff_count);
			assign ctrl.is_alpha   = (g == 3);

			mmbd_avg u_avg (
				.pair  (pair_s1[g]),
				.stored(ram_rdata[g*SW +: SW]),
				.ctrl  (ctrl),
				.result(lane_res[g])
			);
		end else begin : g_unused
			assign lane_res[g] = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			comp_s2 <= lane_res;
			fend_s2 <= fend_s1;
		end
	end

	assign out_valid = valid_s2;
	assign comp0_out = comp_s2[0];
	assign comp1_out = comp_s2[1];
	assign comp2_out = comp_s2[2];
	assign comp3_out = comp_s2[3];
	assign level_end = fend_s2;

	// The line store never sees a write and a read in the same cycle.
	a_ram_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line store written and read in the same cycle");

	// A read is only issued when stage 1 can take its data.
	a_read_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> s1_adv)
		else $error("line store read issued while stage 1 is stalled");

	// A stalled stage 1 keeps its item.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> valid_s1)
		else $error("stage 1 item lost while stalled");

	// A new output result always comes from stage 1.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("output result without a stage 1 item");

	// Frame end returns the block to the first column of an even row.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && frame_end) |=> (colpos_q == '0 && !odd_row_q))
		else $error("position not cleared after frame end");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the 2x2 box-filter mipmap downsampler.
module tb;

	// The register is two bits wide, so the one code that the package leaves
	// unnamed gets a name here. It must act as plain averaging.
	localparam logic [1:0] ALPHA_RESERVED = 2'd3;

	// Generous bound on the run.
	localparam int CYCLE_LIMIT = 300000;

	// Cycles of quiet before a register write, once every expected output pixel is out.
	localparam int DRAIN_CYCLES = 8;

	typedef logic [3:0][15:0] pixel_t;

	// One pixel of the next mipmap level as it appears on the output ports.
	typedef struct packed {
		logic             last;
		logic [3:0][15:0] comp;
	} level_pixel_t;

	typedef enum {PH_PLAIN, PH_LONG_HOLD, PH_CALM, PH_DRAIN} phase_kind_t;

	// The scoreboard keeps its own copy of the line store, the left-pixel hold
	// and the row and column position. It works out each expected output pixel
	// at the moment the pixel that completes a 2x2 block is accepted.
	class mip_scoreboard;
		logic [16:0]  sum_store [4][mmbd_pkg::MAX_WIDTH_DEF / 2];
		pixel_t       left_hold;
		int           column;
		bit           odd_row;
		logic [1:0]   mode;
		logic [2:0]   count;
		logic [1:0]   alpha;
		logic [3:0]   wlog2;
		level_pixel_t due [$];
		int           errors;

		function new();
			left_hold = '0;
			column    = 0;
			odd_row   = 1'b0;
			mode      = mmbd_pkg::MODE_U8;
			count     = 3'd4;
			alpha     = mmbd_pkg::ALPHA_AVG;
			wlog2     = 4'd1;
			errors    = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] val);
			case (idx)
				mmbd_pkg::REG_MODE:  mode  = val[1:0];
				mmbd_pkg::REG_COUNT: count = val[2:0];
				mmbd_pkg::REG_ALPHA: alpha = val[1:0];
				default:             wlog2 = val[3:0];
			endcase
		endfunction

		// Zero acts as two pixels per row; anything wider than the store
		// saturates to the widest row it holds.
		function int row_log2();
			if (wlog2 == 0)
				return 1;
			if (wlog2 > $clog2(mmbd_pkg::MAX_WIDTH_DEF))
				return $clog2(mmbd_pkg::MAX_WIDTH_DEF);
			return int'(wlog2);
		endfunction

		function int lanes_in_use();
			if (count == 0)
				return 1;
			if (count > mmbd_pkg::LANES_DEF)
				return mmbd_pkg::LANES_DEF;
			return int'(count);
		endfunction

		function int component_value(logic [15:0] raw);
			case (mode)
				mmbd_pkg::MODE_U8:  return int'(raw[7:0]);
				mmbd_pkg::MODE_S8:  return int'($signed(raw[7:0]));
				mmbd_pkg::MODE_U16: return int'(raw);
				default:            return int'($signed(raw));
			endcase
		endfunction

		function int stored_pair(logic [16:0] s);
			if (mode[0])
				return int'($signed(s));
			return int'({1'b0, s});
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Called for every accepted input pixel.
		function void note_pixel(pixel_t pix, logic fe);
			int           width;
			int           col;
			int           idx;
			int           pair;
			int           total;
			int           avg;
			logic [15:0]  res;
			level_pixel_t want;

			width = 1 << row_log2();
			col   = column & (width - 1);
			if (col[0] == 1'b0) begin
				left_hold = pix;
			end else begin
				idx  = col >> 1;
				want = '0;
				for (int i = 0; i < lanes_in_use(); i++) begin
					pair = component_value(left_hold[i]) + component_value(pix[i]);
					if (!odd_row) begin
						sum_store[i][idx] = pair[16:0];
					end else begin
						total = pair + stored_pair(sum_store[i][idx]);
						// Signed modes truncate toward zero, unsigned ones floor.
						if (mode[0])
							avg = total / 4;
						else
							avg = total >> 2;
						res = mode[1] ? 16'(avg) : {8'h00, 8'(avg)};
						if (mode == mmbd_pkg::MODE_U8 && i == 3) begin
							if (alpha == mmbd_pkg::ALPHA_FORCE)
								res = {8'h00, mmbd_pkg::ALPHA_FULL};
							else if (alpha == mmbd_pkg::ALPHA_THRESH)
								res = (res[7:0] >= mmbd_pkg::ALPHA_HALF) ?
									{8'h00, mmbd_pkg::ALPHA_FULL} : 16'h0000;
						end
						want.comp[i] = res;
					end
				end
				if (odd_row) begin
					want.last = fe;
					due.push_back(want);
				end
			end

			if (col == width - 1) begin
				column  = 0;
				odd_row = ~odd_row;
			end else begin
				column = col + 1;
			end
			if (fe) begin
				column  = 0;
				odd_row = 1'b0;
			end
		endfunction

		// Called for every output pixel taken from the block.
		function void check_result(level_pixel_t got);
			level_pixel_t want;

			if (due.size() == 0) begin
				$error("level pixel with no block behind it: %h", got);
				errors++;
				return;
			end
			want = due.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got.comp[i] !== want.comp[i]) begin
					$error("comp%0d_out: expected %h, got %h", i, want.comp[i], got.comp[i]);
					errors++;
				end
			end
			if (got.last !== want.last) begin
				$error("level_end: expected %b, got %b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [15:0] comp0_in  = '0;
	logic [15:0] comp1_in  = '0;
	logic [15:0] comp2_in  = '0;
	logic [15:0] comp3_in  = '0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] comp0_out;
	logic [15:0] comp1_out;
	logic [15:0] comp2_out;
	logic [15:0] comp3_out;
	logic        level_end;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	// The sender and receiver both skip idling while this is set, which gives
	// a stretch of back-to-back traffic.
	logic        calm      = 1'b0;
	// Each bump of this token asks the receiver for one long hold-off.
	int          hold_token = 0;
	int          hold_seen  = 0;
	int          hold_left  = 0;
	int          cycle_count = 0;

	mip_scoreboard sb;

	mipmap_box_downsampler_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.comp0_in  (comp0_in),
		.comp1_in  (comp1_in),
		.comp2_in  (comp2_in),
		.comp3_in  (comp3_in),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.comp0_out (comp0_out),
		.comp1_out (comp1_out),
		.comp2_out (comp2_out),
		.comp3_out (comp3_out),
		.level_end (level_end),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #1 clk = ~clk;

	// Both monitors sample at the rising edge, before any of this edge's
	// updates land, so they see exactly what the block saw.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_pixel({comp3_in, comp2_in, comp1_in, comp0_in}, frame_end);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({level_end, comp3_out, comp2_out, comp1_out, comp0_out});
	end

	// The receiver stalls at random, fifteen times in a hundred. A long hold-off
	// lets the block fill up so that it has to stall its own input.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < 15);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** mipmap_box_downsampler_top: FAILED **");
			$finish;
		end
	end

	// A write is a setup phase followed by an access phase. The scoreboard
	// takes the new value at once since writes happen only while idle.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		sb.set_register(idx, val);
	endtask

	task automatic set_config(input logic [1:0] m, input logic [2:0] c, input logic [1:0] a,
		input logic [3:0] w);
		write_reg(mmbd_pkg::REG_MODE, {30'd0, m});
		write_reg(mmbd_pkg::REG_COUNT, {29'd0, c});
		write_reg(mmbd_pkg::REG_ALPHA, {30'd0, a});
		write_reg(mmbd_pkg::REG_WIDTH, {28'd0, w});
	endtask

	// Offers one pixel and holds it until the block takes it. Now and then,
	// unless calm is set, the sender idles afterwards.
	task automatic push_pixel(input pixel_t pix, input logic fe);
		in_valid  <= 1'b1;
		comp0_in  <= pix[0];
		comp1_in  <= pix[1];
		comp2_in  <= pix[2];
		comp3_in  <= pix[3];
		frame_end <= fe;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(2, 1)) @(posedge clk);
		end
	endtask

	task automatic push_block(input pixel_t p0, input pixel_t p1, input pixel_t p2,
		input pixel_t p3, input logic last);
		push_pixel(p0, 1'b0);
		push_pixel(p1, 1'b0);
		push_pixel(p2, 1'b0);
		push_pixel(p3, last);
	endtask

	// Stops offering pixels and waits until every expected output pixel has
	// come out, then waits DRAIN_CYCLES more for the block to go quiet. The first
	// wait lets the monitor note the last accepted pixel.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Components lean toward the extremes of both the 8-bit and 16-bit codes.
	function automatic logic [15:0] pick_comp();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return {8'($urandom), 8'h80};
			5: return {8'($urandom), 8'h7F};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		return {pick_comp(), pick_comp(), pick_comp(), pick_comp()};
	endfunction

	// Sends whole frames of random pixels. Most frames are complete pairs of
	// rows; some end early on a random pixel. Every frame, and so the phase,
	// ends on a pixel marked as frame end, which brings the block back to the
	// top-left corner and keeps odd rows from reading stale line-store entries.
	task automatic run_phase(input logic [1:0] m, input logic [2:0] c, input logic [1:0] a,
		input logic [3:0] w, input int items, input phase_kind_t kind);
		int width;
		int rows;
		int total;
		int sent;
		bit drained;

		set_config(m, c, a, w);
		width   = 1 << sb.row_log2();
		sent    = 0;
		drained = 1'b0;
		if (kind == PH_LONG_HOLD)
			hold_token <= hold_token + 1;
		if (kind == PH_CALM)
			calm <= 1'b1;
		while (sent < items) begin
			rows  = (width >= 64) ? 2 : 2 * $urandom_range(4, 1);
			total = width * rows;
			if ($urandom_range(99) < 15)
				total = $urandom_range(total, 1);
			if (total > items - sent)
				total = items - sent;
			for (int k = 1; k <= total; k++)
				push_pixel(random_pixel(), k == total);
			sent += total;
			// Once per drain phase the sender waits for the output to empty.
			if (kind == PH_DRAIN && !drained) begin
				settle();
				drained = 1'b1;
			end
		end
		if (kind == PH_CALM)
			calm <= 1'b0;
		settle();
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed blocks on two-pixel rows. In unsigned 8-bit mode the first
		// block checks zero, all ones with the high byte ignored, flooring and
		// an alpha average right on the threshold. The second puts alpha just
		// below it.
		set_config(mmbd_pkg::MODE_U8, 3'd4, mmbd_pkg::ALPHA_THRESH, 4'd1);
		push_block({16'h0080, 16'h0000, 16'hFFFF, 16'h0000},
			{16'h0080, 16'h0000, 16'hFFFF, 16'h0000},
			{16'h0080, 16'h0000, 16'hFFFF, 16'h0000},
			{16'h0080, 16'h0003, 16'hFFFF, 16'h0000}, 1'b0);
		push_block({16'h007F, 16'hFF00, 16'h00FF, 16'h0001},
			{16'h007F, 16'hFF00, 16'h00FF, 16'h0002},
			{16'h007F, 16'hFF00, 16'h00FF, 16'h0003},
			{16'h0080, 16'hFF00, 16'h00FF, 16'h0004}, 1'b0);
		// A frame that ends on its very first pixel gives no output pixel.
		push_pixel({16'h5555, 16'h5555, 16'h5555, 16'h5555}, 1'b1);
		// A frame end on a block's last pixel marks the level's last pixel.
		push_block({16'h0004, 16'h0003, 16'h0002, 16'h0001},
			{16'h0008, 16'h0007, 16'h0006, 16'h0005},
			{16'h00F0, 16'h00E0, 16'h00D0, 16'h00C0},
			{16'h00FF, 16'h00FE, 16'h00FD, 16'h00FC}, 1'b1);
		settle();

		// Signed 8-bit: most negative value, and small negative sums that
		// must truncate toward zero rather than floor.
		set_config(mmbd_pkg::MODE_S8, 3'd4, mmbd_pkg::ALPHA_AVG, 4'd1);
		push_block({16'h007F, 16'hFFFB, 16'hFFFF, 16'hFF80},
			{16'h007F, 16'h0000, 16'h0000, 16'hFF80},
			{16'h007F, 16'h0000, 16'h0000, 16'hFF80},
			{16'h007F, 16'h0000, 16'h0000, 16'hFF80}, 1'b1);
		settle();

		// Unsigned 16-bit: the largest sum needs all eighteen bits.
		set_config(mmbd_pkg::MODE_U16, 3'd4, mmbd_pkg::ALPHA_AVG, 4'd1);
		push_block({16'h0001, 16'h0000, 16'h0000, 16'hFFFF},
			{16'h0002, 16'h0000, 16'h0000, 16'hFFFF},
			{16'h0003, 16'h0000, 16'h0000, 16'hFFFF},
			{16'h0004, 16'h0003, 16'h0000, 16'hFFFF}, 1'b1);
		settle();

		// Signed 16-bit: both extremes, where the stored pair sum reaches the
		// sign bit of the line store, and truncation of small negatives.
		set_config(mmbd_pkg::MODE_S16, 3'd4, mmbd_pkg::ALPHA_AVG, 4'd1);
		push_block({16'hFFFB, 16'hFFFD, 16'h7FFF, 16'h8000},
			{16'h0000, 16'h0000, 16'h7FFF, 16'h8000},
			{16'h0000, 16'h0000, 16'h7FFF, 16'h8000},
			{16'h0000, 16'h0000, 16'h7FFF, 16'h8000}, 1'b1);
		settle();

		// Random phases. They walk through every mode and alpha setting,
		// component counts zero and two to seven, and row widths from the
		// smallest, including the zero that acts as two pixels, upward.
		run_phase(mmbd_pkg::MODE_U8, 3'd4, mmbd_pkg::ALPHA_AVG, 4'd4, 50, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_U8, 3'd4, mmbd_pkg::ALPHA_FORCE, 4'd3, 60, PH_LONG_HOLD);
		run_phase(mmbd_pkg::MODE_U8, 3'd4, mmbd_pkg::ALPHA_THRESH, 4'd2, 60, PH_CALM);
		run_phase(mmbd_pkg::MODE_U8, 3'd4, ALPHA_RESERVED, 4'd1, 60, PH_DRAIN);
		run_phase(mmbd_pkg::MODE_S8, 3'd3, mmbd_pkg::ALPHA_THRESH, 4'd5, 60, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_U16, 3'd2, mmbd_pkg::ALPHA_FORCE, 4'd3, 60, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_S16, 3'd0, mmbd_pkg::ALPHA_AVG, 4'd0, 50, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_U16, 3'd7, mmbd_pkg::ALPHA_AVG, 4'd6, 50, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_S8, 3'd5, mmbd_pkg::ALPHA_FORCE, 4'd2, 60, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_S16, 3'd4, mmbd_pkg::ALPHA_THRESH, 4'd3, 60, PH_PLAIN);
		run_phase(mmbd_pkg::MODE_U8, 3'd6, mmbd_pkg::ALPHA_THRESH, 4'd4, 60, PH_PLAIN);

		// A short frame with a width code beyond the store, which has to
		// saturate to the widest row. The frame ends early within the even
		// row, so it only writes the line store.
		run_phase(mmbd_pkg::MODE_U8, 3'd4, mmbd_pkg::ALPHA_FORCE, 4'd15, 40, PH_PLAIN);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("** mipmap_box_downsampler_top: PASSED **");
		else
			$display("** mipmap_box_downsampler_top: FAILED **");
		$finish;
	end

endmodule

[sim.f]
hdl/mmbd_pkg.sv
hdl/mmbd_ram.sv
hdl/mmbd_avg.sv
hdl/mipmap_box_downsampler_top.sv
tb/sv/tb.sv
